@@ rtl/round_robin_capacity_placement_macros.svh @@
// ----------------------------------------------------------------------------
// Round-robin capacity placement: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_CAPACITY_PLACEMENT_MACROS_SVH
`define ROUND_ROBIN_CAPACITY_PLACEMENT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define RRCP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rrcp: invariant violated");

// Antecedent in this cycle implies consequent in the next.
`define RRCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rrcp: sequencing violated");

`endif

@@ rtl/rrcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrcp_pkg
// Types and fixed field widths for the round-robin capacity placement block.
// ----------------------------------------------------------------------------
package rrcp_pkg;

    localparam int CAP_W  = 48;
    localparam int TAG_W  = 16;
    localparam int SLOT_W = 3;
    localparam int ACT_W  = 4;

    // Stream payload layout
    localparam int IN_TDATA_W  = 120;   // 115 used bits, padded to bytes
    localparam int OUT_TDATA_W = 72;    // 67 used bits, padded to bytes
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + TAG_W + CAP_W);

    // Request kind carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    // Register map
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic [1:0] {
        STAT_PLACED = 2'd0,
        STAT_NOFIT  = 2'd1,
        STAT_LOADED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic [CAP_W-1:0]   bytes;
    } t_result;

endpackage

@@ rtl/rrcp_tgt_mem.sv @@
// ----------------------------------------------------------------------------
// rrcp_tgt_mem
// Target table: capacity and tag per entry, one write and one registered
// read port. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module rrcp_tgt_mem
    import rrcp_pkg::*;
#(
    parameter int NUM_TARGETS = 8,
    parameter int IDX_W       = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [CAP_W-1:0]  i_wcap,
    input  logic [TAG_W-1:0]  i_wtag,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [CAP_W-1:0]  o_rcap,
    output logic [TAG_W-1:0]  o_rtag
);

    logic [CAP_W+TAG_W-1:0] r_mem [NUM_TARGETS];
    logic [NUM_TARGETS-1:0] r_valid;
    logic [CAP_W+TAG_W-1:0] r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wtag, i_wcap};
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rcap = r_rd_valid ? r_rd_data[CAP_W-1:0]           : '0;
    assign o_rtag = r_rd_valid ? r_rd_data[CAP_W+TAG_W-1:CAP_W] : '0;

endmodule

@@ rtl/rrcp_alu.sv @@
// ----------------------------------------------------------------------------
// rrcp_alu
// Shared fit unit: one subtract gives both the fit test and the new capacity.
// ----------------------------------------------------------------------------
module rrcp_alu
    import rrcp_pkg::*;
(
    input  logic [CAP_W-1:0] i_cap,
    input  logic [CAP_W-1:0] i_size,
    output logic             o_fits,
    output logic [CAP_W-1:0] o_diff
);

    logic [CAP_W:0] diff;

    // borrow out clear means cap >= size
    assign diff   = {1'b0, i_cap} - {1'b0, i_size};
    assign o_fits = ~diff[CAP_W];
    assign o_diff = diff[CAP_W-1:0];

endmodule

@@ rtl/rrcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrcp_ctrl
// Sequencer: takes one item, walks the table from the start pointer one read
// per cycle, tests each entry with the shared fit unit, then commits.
// ----------------------------------------------------------------------------
`include "round_robin_capacity_placement_macros.svh"

module rrcp_ctrl
    import rrcp_pkg::*;
#(
    parameter int NUM_TARGETS = 8,
    parameter int IDX_W       = 3,
    parameter int CNT_W       = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [CAP_W-1:0]  i_load_cap,
    input  logic [TAG_W-1:0]  i_load_tag,
    input  logic [CAP_W-1:0]  i_place_size,
    input  logic [CNT_W-1:0]  i_eff_cnt,
    // result hand-off
    input  logic              i_out_free,
    output logic              o_push,
    output t_result           o_res,
    // table
    output logic              o_mem_we,
    output logic [IDX_W-1:0]  o_mem_waddr,
    output logic [CAP_W-1:0]  o_mem_wcap,
    output logic [TAG_W-1:0]  o_mem_wtag,
    output logic              o_mem_re,
    output logic [IDX_W-1:0]  o_mem_raddr,
    input  logic [TAG_W-1:0]  i_mem_tag,
    // fit unit
    output logic [CAP_W-1:0]  o_size,
    input  logic              i_fits,
    input  logic [CAP_W-1:0]  i_diff
);

    t_state              r_state,    n_state;
    logic [IDX_W-1:0]    r_ptr,      n_ptr;
    logic [CAP_W-1:0]    r_size,     n_size;
    logic [IDX_W-1:0]    r_iss_idx,  n_iss_idx;
    logic [CNT_W-1:0]    r_iss_left, n_iss_left;
    logic                r_cmp_vld,  n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx,  n_cmp_idx;
    logic                r_cmp_last, n_cmp_last;
    logic                r_wr_en,    n_wr_en;
    logic [IDX_W-1:0]    r_wr_addr,  n_wr_addr;
    logic [CAP_W-1:0]    r_wr_cap,   n_wr_cap;
    logic [TAG_W-1:0]    r_wr_tag,   n_wr_tag;
    t_result             r_res,      n_res;

    logic [IDX_W-1:0]    start_idx;
    logic                slot_ok;

    // assertion terms
    logic                last_cmp;
    logic                push_placed;
    logic                push_unplaced;
    logic                res_zero;

    function automatic logic [IDX_W-1:0] f_wrap(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] v;
        v = CNT_W'(idx) + CNT_W'(1);
        return (v >= cnt) ? '0 : IDX_W'(v);
    endfunction

    // stale pointer (count lowered) restarts at entry zero
    assign start_idx = (CNT_W'(r_ptr) < i_eff_cnt) ? r_ptr : '0;
    assign slot_ok   = (32'(i_slot) < 32'(NUM_TARGETS));

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_size      = r_size;
    assign o_mem_waddr = r_wr_addr;
    assign o_mem_wcap  = r_wr_cap;
    assign o_mem_wtag  = r_wr_tag;
    assign o_mem_raddr = r_iss_idx;
    assign o_res       = r_res;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_size     = r_size;
        n_iss_idx  = r_iss_idx;
        n_iss_left = r_iss_left;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_cmp_last = r_cmp_last;
        n_wr_en    = r_wr_en;
        n_wr_addr  = r_wr_addr;
        n_wr_cap   = r_wr_cap;
        n_wr_tag   = r_wr_tag;
        n_res      = r_res;
        o_push     = 1'b0;
        o_mem_we   = 1'b0;
        o_mem_re   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        n_wr_en   = slot_ok;
                        n_wr_addr = IDX_W'(i_slot);
                        n_wr_cap  = i_load_cap;
                        n_wr_tag  = i_load_tag;
                        n_res     = '{status: STAT_LOADED, slot: '0, tag: '0, bytes: '0};
                        n_state   = ST_DONE;
                    end else begin
                        n_wr_en    = 1'b0;
                        n_size     = i_place_size;
                        n_iss_idx  = start_idx;
                        n_iss_left = i_eff_cnt;
                        n_cmp_vld  = 1'b0;
                        n_ptr      = f_wrap(start_idx, i_eff_cnt);
                        n_state    = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // read issue stage
                n_cmp_vld = (r_iss_left != '0);
                if (r_iss_left != '0) begin
                    o_mem_re   = 1'b1;
                    n_iss_idx  = f_wrap(r_iss_idx, i_eff_cnt);
                    n_iss_left = r_iss_left - CNT_W'(1);
                    n_cmp_idx  = r_iss_idx;
                    n_cmp_last = (r_iss_left == CNT_W'(1));
                end
                // compare stage on last cycle's read
                if (r_cmp_vld) begin
                    if (i_fits) begin
                        n_wr_en   = 1'b1;
                        n_wr_addr = r_cmp_idx;
                        n_wr_cap  = i_diff;
                        n_wr_tag  = i_mem_tag;
                        n_res     = '{status: STAT_PLACED, slot: SLOT_W'(r_cmp_idx),
                                      tag: i_mem_tag, bytes: r_size};
                        n_cmp_vld = 1'b0;
                        n_state   = ST_DONE;
                    end else if (r_cmp_last) begin
                        n_res     = '{status: STAT_NOFIT, slot: '0, tag: '0, bytes: '0};
                        n_cmp_vld = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (i_out_free) begin
                    o_push   = 1'b1;
                    o_mem_we = r_wr_en;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_iss_idx  <= n_iss_idx;
        r_iss_left <= n_iss_left;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_last <= n_cmp_last;
        r_wr_en    <= n_wr_en;
        r_wr_addr  <= n_wr_addr;
        r_wr_cap   <= n_wr_cap;
        r_wr_tag   <= n_wr_tag;
        r_res      <= n_res;
    end

    assign last_cmp      = (r_state == ST_SCAN) && r_cmp_vld && r_cmp_last;
    assign push_placed   = o_push && (o_res.status == STAT_PLACED);
    assign push_unplaced = o_push && (o_res.status != STAT_PLACED);
    assign res_zero      = (o_res.slot == '0) && (o_res.tag == '0) && (o_res.bytes == '0);

    `RRCP_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state != ST_IDLE)
    `RRCP_ASSERT_NEXT(a_last_cmp_ends_scan, last_cmp, r_state == ST_DONE)
    `RRCP_ASSERT_ALWAYS(a_placed_writes_back, !push_placed || o_mem_we)
    `RRCP_ASSERT_ALWAYS(a_unplaced_zero, !push_unplaced || res_zero)

endmodule

@@ rtl/round_robin_capacity_placement.sv @@
// ----------------------------------------------------------------------------
// round_robin_capacity_placement
// Round-robin first-fit placement of blobs onto a table of storage targets.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel; tuser selects a table load (0) or a
//   placement (1). Each item yields exactly one result transfer on m_axis,
//   tuser giving placed (0), no fit (1) or entry loaded (2).
//   A load goes straight to its result. A placement tests targets from the
//   start pointer, at most the active count of them, and stops at the first
//   that fits; the table is walked one registered read per cycle through a
//   single fit unit. No new item is taken until the previous result has
//   been pushed into the output register.
//   Only one item is in flight: s_axis_tready is high only while idle, but
//   a finished result held in the output register does not block the next
//   item from being taken.
//   active_targets sits at APB byte address 0; write it only while idle.
// Reset (synchronous, active low): table reads as all zero, start pointer
//   zero, active_targets 8, output register empty.
// Back-pressure: if m_axis_tready is low the result stays in the output
//   register; a following item is accepted and worked on, then waits for
//   the register to empty before committing its table write-back.
// ----------------------------------------------------------------------------
module round_robin_capacity_placement
    import rrcp_pkg::*;
#(
    parameter int NUM_TARGETS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // item stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // [2:0] slot, [50:3] load_capacity, [66:51] load_tag, [114:67] place_size
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] req_type
    input  logic                    i_s_axis_tuser,
    // result stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // [2:0] chosen_slot, [18:3] chosen_tag, [66:19] placed_bytes
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]              o_m_axis_tuser,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int CNT_W = $clog2(NUM_TARGETS + 1);

    // ---- configuration register -------------------------------------------
    logic [ACT_W-1:0] r_active;
    logic             cfg_wr;
    logic [CNT_W-1:0] eff_cnt;

    assign pready = 1'b1;
    // only register 0 exists; bit 2 picks the next word, which is unmapped
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-ACT_W){1'b0}}, r_active};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    // zero counts as one, anything past the table as the full table
    always_comb begin
        priority if (r_active == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (32'(r_active) > 32'(NUM_TARGETS)) begin
            eff_cnt = CNT_W'(NUM_TARGETS);
        end else begin
            eff_cnt = CNT_W'(r_active);
        end
    end

    // ---- output register ------------------------------------------------
    logic    r_out_vld;
    t_result r_out;
    logic    out_free;
    logic    push;
    t_result res;

    assign out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.bytes, r_out.tag, r_out.slot};

    // ---- sequencer, table and fit unit ------------------------------------
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CAP_W-1:0]  mem_wcap;
    logic [TAG_W-1:0]  mem_wtag;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [CAP_W-1:0]  mem_rcap;
    logic [TAG_W-1:0]  mem_rtag;
    logic [CAP_W-1:0]  size;
    logic              fits;
    logic [CAP_W-1:0]  diff;

    rrcp_ctrl #(
        .NUM_TARGETS (NUM_TARGETS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_slot       (i_s_axis_tdata[2:0]),
        .i_load_cap   (i_s_axis_tdata[50:3]),
        .i_load_tag   (i_s_axis_tdata[66:51]),
        .i_place_size (i_s_axis_tdata[114:67]),
        .i_eff_cnt    (eff_cnt),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wcap   (mem_wcap),
        .o_mem_wtag   (mem_wtag),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_tag    (mem_rtag),
        .o_size       (size),
        .i_fits       (fits),
        .i_diff       (diff)
    );

    rrcp_tgt_mem #(
        .NUM_TARGETS (NUM_TARGETS),
        .IDX_W       (IDX_W)
    ) u_tgt_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wcap  (mem_wcap),
        .i_wtag  (mem_wtag),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rcap  (mem_rcap),
        .o_rtag  (mem_rtag)
    );

    rrcp_alu u_alu (
        .i_cap  (mem_rcap),
        .i_size (size),
        .o_fits (fits),
        .o_diff (diff)
    );

endmodule

@@ verif/tb_round_robin_capacity_placement.sv @@
// ----------------------------------------------------------------------------
// tb_round_robin_capacity_placement
// Self-checking bench for the round-robin first-fit placement block: a short
// directed table, then constrained-by-hand random loads and placements under
// several idling patterns and active-target settings, scored against a
// local mirror of the target table and start pointer or a typed-in status.
// ----------------------------------------------------------------------------
module tb_round_robin_capacity_placement;
    import rrcp_pkg::*;

    localparam int NUM_TARGETS  = 8;
    localparam int WDOG_LIMIT   = 4000;   // cycles with no transfer at all
    localparam int TAIL_CYCLES  = 20;     // longer than a worst-case placement
    localparam int SEG_ITEMS    = 50;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct packed {
        logic              req;
        logic [SLOT_W-1:0] slot;
        logic [CAP_W-1:0]  cap;
        logic [TAG_W-1:0]  tag;
        logic [CAP_W-1:0]  size;
    } t_req_item;

    typedef struct {
        t_row_kind         kind;
        t_req_item         item;
        logic [ACT_W-1:0]  act;
        logic              has_exp;   // status typed in, other fields zero
        t_status           exp_st;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [2:0] slot, [50:3] load_capacity, [66:51] load_tag, [114:67] place_size
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // [0] req_type
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b1;
    // [2:0] chosen_slot, [18:3] chosen_tag, [66:19] placed_bytes
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // [1:0] status
    logic [1:0]             o_m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    round_robin_capacity_placement #(
        .NUM_TARGETS (NUM_TARGETS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 2-unit period, high then low
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mirror of the block state, updated at each accepted transfer
    // ------------------------------------------------------------------------
    logic [CAP_W-1:0]  cap_mirror [NUM_TARGETS];
    logic [TAG_W-1:0]  tag_mirror [NUM_TARGETS];
    logic [SLOT_W-1:0] rr_mirror;
    logic [ACT_W-1:0]  active_mirror;

    t_result   pending_results [$];
    int        mismatch_count = 0;
    int        tx_idle_pct = 0;     // chance in 100 of a sender gap cycle
    int        rx_stall_pct = 0;    // chance in 100 of a receiver stall cycle
    t_req_item cur_item;            // item currently on the slave side
    logic      cur_has_exp = 1'b0;
    t_status   cur_exp_st = STAT_PLACED;
    t_stim_row directed_rows [$];

    initial begin
        for (int i = 0; i < NUM_TARGETS; i++) begin
            cap_mirror[i] = '0;
            tag_mirror[i] = '0;
        end
        rr_mirror     = '0;
        active_mirror = ACTIVE_RESET;
    end

    // Applies one item to the mirror and returns the result it should cause.
    function automatic t_result predict_placement(input t_req_item it);
        t_result r;
        int      n;
        int      first;
        int      idx;
        logic    found;
        r = '0;
        if (it.req == REQ_LOAD) begin
            // slot is 3 bits, so every load lands in the table
            cap_mirror[it.slot] = it.cap;
            tag_mirror[it.slot] = it.tag;
            r.status = STAT_LOADED;
            return r;
        end
        // out-of-range active count clamps to 1..NUM_TARGETS
        n = (active_mirror == 0) ? 1 :
            ((active_mirror > NUM_TARGETS) ? NUM_TARGETS : int'(active_mirror));
        // stale pointer (count lowered under it) restarts the scan at 0
        first = (int'(rr_mirror) < n) ? int'(rr_mirror) : 0;
        rr_mirror = (first + 1 >= n) ? '0 : SLOT_W'(first + 1);
        r.status = STAT_NOFIT;
        idx = first;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && cap_mirror[idx] >= it.size) begin
                cap_mirror[idx] = cap_mirror[idx] - it.size;
                r.status = STAT_PLACED;
                r.slot   = SLOT_W'(idx);
                r.tag    = tag_mirror[idx];
                r.bytes  = it.size;
                found    = 1'b1;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: both sides sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : score
        t_result want;
        t_result typed;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%0h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_m_axis_tuser);
                    check_field("chosen_slot", want.slot, o_m_axis_tdata[2:0]);
                    check_field("chosen_tag", want.tag, o_m_axis_tdata[18:3]);
                    check_field("placed_bytes", want.bytes, o_m_axis_tdata[66:19]);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                // mirror always advances; typed rows override the expectation
                want = predict_placement(cur_item);
                if (cur_has_exp) begin
                    typed = '0;
                    typed.status = cur_exp_st;
                    pending_results.push_back(typed);
                end else begin
                    pending_results.push_back(want);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transfer on either stream or the APB port restarts it
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Presents one item; returns at the falling edge after its transfer with
    // tvalid still high, so back-to-back items keep it up.
    task automatic send_item(input t_req_item it, input logic has_exp,
                             input t_status exp_st);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        cur_item        = it;
        cur_has_exp     = has_exp;
        cur_exp_st      = exp_st;
        i_s_axis_tdata  = {5'b0, it.size, it.tag, it.cap, it.slot};
        i_s_axis_tuser  = it.req;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain;
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0 || !o_s_axis_tready) @(negedge i_clk);
    endtask

    // Writes active_targets while idle, then reads it back.
    task automatic write_active(input logic [ACT_W-1:0] v);
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = '0;
        pwdata  = {28'b0, v};
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        active_mirror = v;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("active_targets", {60'b0, v}, {32'b0, prdata});
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_item(input logic req, input logic [SLOT_W-1:0] slot,
                            input logic [CAP_W-1:0] cap, input logic [TAG_W-1:0] tag,
                            input logic [CAP_W-1:0] size, input logic has_exp,
                            input t_status exp_st);
        t_stim_row row;
        row.kind    = ROW_ITEM;
        row.item    = '{req, slot, cap, tag, size};
        row.act     = '0;
        row.has_exp = has_exp;
        row.exp_st  = exp_st;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [ACT_W-1:0] act);
        t_stim_row row;
        row.kind    = ROW_CFG;
        row.item    = '0;
        row.act     = act;
        row.has_exp = 1'b0;
        row.exp_st  = STAT_PLACED;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stim
        t_req_item        it;
        logic [ACT_W-1:0] seg_active [8];
        int               pick;

        seg_active = '{4'd8, 4'd3, 4'd1, 4'd8, 4'd5, 4'd0, 4'd15, 4'd2};

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table. Status typed in only where obvious from reset,
        // loads and an empty table; the rest goes through the mirror.
        // zero-size blob on an all-empty table still places on target 0
        add_item(REQ_PLACE, 3'd5, CAP_MAX, TAG_MAX, '0, 1'b1, STAT_PLACED);
        // empty table: nothing fits one byte
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd1, 1'b1, STAT_NOFIT);
        add_item(REQ_LOAD, 3'd0, CAP_MAX, TAG_MAX, CAP_MAX, 1'b1, STAT_LOADED);
        add_item(REQ_LOAD, 3'd7, '0, 16'hA5A5, '0, 1'b1, STAT_LOADED);
        add_item(REQ_LOAD, 3'd3, 48'd100, 16'h1234, 48'h5A5A_5A5A_5A5A, 1'b1, STAT_LOADED);
        // largest blob wraps the scan round to target 0
        add_item(REQ_PLACE, 3'd2, 48'hA5A5_A5A5_A5A5, '0, CAP_MAX, 1'b0, STAT_PLACED);
        // exact fit on target 3
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd100, 1'b0, STAT_PLACED);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd1, 1'b0, STAT_PLACED);
        add_item(REQ_LOAD, 3'd5, 48'd1000, 16'h00FF, '0, 1'b1, STAT_LOADED);
        // one target only; pointer left stale above the count
        add_cfg(4'd1);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd10, 1'b0, STAT_PLACED);
        add_item(REQ_LOAD, 3'd0, 48'd50, 16'h0001, '0, 1'b1, STAT_LOADED);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd20, 1'b0, STAT_PLACED);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd40, 1'b0, STAT_PLACED);
        // zero count behaves as one
        add_cfg(4'd0);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd30, 1'b0, STAT_PLACED);
        // count above the table size behaves as the full table
        add_cfg(4'd15);
        add_item(REQ_PLACE, 3'd0, '0, '0, 48'd1000, 1'b0, STAT_PLACED);
        add_item(REQ_PLACE, 3'd0, '0, '0, '0, 1'b0, STAT_PLACED);
        add_cfg(4'd8);
        add_item(REQ_LOAD, 3'd2, CAP_MAX, 16'h8000, '0, 1'b1, STAT_LOADED);
        add_item(REQ_PLACE, 3'd0, '0, '0, CAP_MAX, 1'b0, STAT_PLACED);
        add_item(REQ_PLACE, 3'd0, '0, '0, CAP_MAX, 1'b0, STAT_PLACED);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_active(directed_rows[i].act);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].has_exp,
                          directed_rows[i].exp_st);
            end
        end

        // Random part: eight segments, each with its own active count and
        // one of four idling patterns.
        for (int seg = 0; seg < 8; seg++) begin
            write_active(seg_active[seg]);
            case (seg % 4)
                0: begin
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 66; rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;  rx_stall_pct = 66;
                end
                default: begin
                    tx_idle_pct = 17; rx_stall_pct = 17;
                end
            endcase
            for (int k = 0; k < SEG_ITEMS; k++) begin
                if (k == SEG_ITEMS / 2) drain();
                // unused fields carry random bits as well
                it.req  = ($urandom_range(3) != 0) ? REQ_PLACE : REQ_LOAD;
                it.slot = SLOT_W'($urandom);
                it.tag  = TAG_W'($urandom);
                pick    = $urandom_range(5);
                case (pick)
                    0, 1, 2: it.cap = CAP_W'($urandom_range(2000));
                    3:       it.cap = CAP_W'({$urandom, $urandom});
                    4:       it.cap = CAP_MAX;
                    default: it.cap = '0;
                endcase
                // sizes lean small so targets fill up over several placements
                pick = $urandom_range(9);
                case (pick)
                    0:          it.size = '0;
                    1, 2, 3, 4: it.size = CAP_W'($urandom_range(300));
                    5:          it.size = cap_mirror[$urandom_range(NUM_TARGETS - 1)];
                    6:          it.size = cap_mirror[$urandom_range(NUM_TARGETS - 1)] + 1'b1;
                    7:          it.size = CAP_W'({$urandom, $urandom});
                    8:          it.size = CAP_MAX;
                    default:    it.size = CAP_W'($urandom_range(2000));
                endcase
                send_item(it, 1'b0, STAT_PLACED);
            end
        end

        drain();
        tx_idle_pct = 0;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rrcp_pkg.sv
rtl/rrcp_tgt_mem.sv
rtl/rrcp_alu.sv
rtl/rrcp_ctrl.sv
rtl/round_robin_capacity_placement.sv
verif/tb_round_robin_capacity_placement.sv
